>>> rtl/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants for the flash request sequencer.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned OFS_W  = 24;

  localparam logic [LEN_W-1:0]  PAGE_LEN  = LEN_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_BYTES);
  localparam logic [31:0]       WORD_ONES = 32'hFFFF_FFFF;

  // queue depth and the room needed for the worst-case item
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned MAX_RESULTS = 2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PROGRAM = 2'd0,
    KIND_ERASE   = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_ERASE = 2'd2
  } mode_t;

  typedef enum logic {
    OP_ERASE = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    CFG_REGION_BASE = 1'b0,
    CFG_REGION_SIZE = 1'b1
  } cfg_index_t;

  // error_flags bit positions
  localparam int unsigned ERR_RANGE     = 0;
  localparam int unsigned ERR_UNALIGNED = 1;
  localparam int unsigned ERR_FAULT     = 2;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] command_address;
    logic [31:0] program_word;
    logic        error_range;
    logic        error_unaligned;
    logic        error_fault;
    logic        last;
  } result_t;

  function automatic result_t done_result(input logic [2:0] flags);
    result_t r;
    r.kind            = KIND_DONE;
    r.command_address = '0;
    r.program_word    = '0;
    r.error_range     = flags[ERR_RANGE];
    r.error_unaligned = flags[ERR_UNALIGNED];
    r.error_fault     = flags[ERR_FAULT];
    r.last            = 1'b1;
    return r;
  endfunction

  function automatic result_t cmd_result(input kind_t k, input logic [31:0] addr,
                                         input logic [31:0] word, input logic last);
    result_t r;
    r.kind            = k;
    r.command_address = addr;
    r.program_word    = word;
    r.error_range     = 1'b0;
    r.error_unaligned = 1'b0;
    r.error_fault     = 1'b0;
    r.last            = last;
    return r;
  endfunction

endpackage

>>> rtl/flash_request_sequencer.sv
// ----------------------------------------------------------------------------
// flash_request_sequencer
// Checks flash erase/write requests against the region, issues page erase
// and program word commands, and closes each request with a done item.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid/in_ready    action, request_offset, request_length,
//                                 op_kind, data_byte, erase_fault
//   out      out_valid/out_ready  kind, command_address, program_word,
//                                 error_range, error_unaligned, error_fault,
//                                 last
//   cfg      cfg_write            cfg_index, cfg_data
//
// One item per cycle while in_ready is high: each item is decoded against the
// state registers in the cycle it is accepted, and its zero, one or two
// results enter a four-entry result queue; the first can show next cycle.
// in_ready drops while the queue holds more than two results, so a stalled
// output stops input after two to three result-bearing items. Sync reset
// clears state and empties the queue; region registers reset to zero.
// ----------------------------------------------------------------------------
module flash_request_sequencer
  import frs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [23:0] request_offset,
  input  logic [24:0] request_length,
  input  logic        op_kind,
  input  logic [7:0]  data_byte,
  input  logic        erase_fault,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] command_address,
  output logic [31:0] program_word,
  output logic        error_range,
  output logic        error_unaligned,
  output logic        error_fault,
  output logic        last
);

  logic [ADDR_W-1:0] region_base;
  logic [LEN_W-1:0]  region_size;

  mode_t             mode, mode_next;
  logic [ADDR_W-1:0] next_address, next_address_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [31:0]       word_buffer, word_buffer_next;
  logic [1:0]        lane_pointer, lane_pointer_next;
  logic [2:0]        error_flags, error_flags_next;

  logic              fire;
  action_t           act;
  logic [ADDR_W-1:0] start_addr;
  logic [LEN_W:0]    req_end;
  logic              range_bad;
  logic              align_bad;
  logic              start_ok;
  logic [2:0]        step_flags;
  logic [31:0]       merged;
  logic [1:0]        lane_inc;
  logic [LEN_W-1:0]  bytes_dec;
  logic              word_out;
  logic [LEN_W-1:0]  erase_left;
  logic [LEN_W-1:0]  erase_rem;

  logic [1:0]        push_count;
  result_t           push0, push1;
  logic              q_room;
  result_t           head;

  assign act      = action_t'(action);
  assign fire     = in_valid && in_ready;
  assign in_ready = q_room;

  // ---- start checks
  assign start_addr = region_base + ADDR_W'(request_offset);
  assign req_end    = (LEN_W+1)'(request_offset) + (LEN_W+1)'(request_length);
  assign range_bad  = req_end > (LEN_W+1)'(region_size);
  assign align_bad  = (start_addr[PAGE_BITS-1:0] != '0) ||
                      (request_length[PAGE_BITS-1:0] != '0);
  assign start_ok   = (mode == MODE_IDLE);

  // ---- write packing
  always_comb begin
    merged = word_buffer;
    merged[{lane_pointer, 3'b000} +: 8] = data_byte;
  end
  assign lane_inc  = lane_pointer + 2'd1;
  assign bytes_dec = (bytes_left != '0) ? bytes_left - LEN_W'(1) : bytes_left;
  assign word_out  = (lane_inc == 2'd0) || (bytes_dec == '0);

  // ---- erase stepping: on start the length is the count, else the register
  assign erase_left = (act == ACT_START) ? request_length : bytes_left;
  assign erase_rem  = (erase_left < PAGE_LEN) ? '0 : erase_left - PAGE_LEN;
  assign step_flags = error_flags | {erase_fault, 2'b00};

  // ---- next mode
  always_comb begin
    mode_next = mode;
    if (fire) begin
      case (act)
        ACT_START: begin
          if (start_ok) begin
            if (range_bad) begin
              mode_next = MODE_IDLE;
            end else if (op_t'(op_kind) == OP_ERASE) begin
              mode_next = (align_bad || request_length == '0) ? MODE_IDLE : MODE_ERASE;
            end else begin
              mode_next = (request_length == '0) ? MODE_IDLE : MODE_WRITE;
            end
          end
        end
        ACT_DATA: begin
          if (mode == MODE_WRITE && word_out && bytes_dec == '0) begin
            mode_next = MODE_IDLE;
          end
        end
        ACT_STEP: begin
          if (mode == MODE_ERASE && bytes_left == '0) begin
            mode_next = MODE_IDLE;
          end
        end
        default: mode_next = mode;
      endcase
    end
  end

  // ---- datapath and results
  always_comb begin
    next_address_next = next_address;
    bytes_left_next   = bytes_left;
    word_buffer_next  = word_buffer;
    lane_pointer_next = lane_pointer;
    error_flags_next  = error_flags;
    push_count        = 2'd0;
    push0             = done_result(error_flags);
    push1             = done_result(error_flags);
    if (fire) begin
      case (act)
        ACT_START: begin
          if (start_ok) begin
            next_address_next = start_addr;
            bytes_left_next   = request_length;
            word_buffer_next  = WORD_ONES;
            lane_pointer_next = start_addr[1:0];
            error_flags_next  = '0;
            if (range_bad) begin
              error_flags_next[ERR_RANGE] = 1'b1;
              push_count = 2'd1;
              push0      = done_result(3'b001 << ERR_RANGE);
            end else if (op_t'(op_kind) == OP_ERASE) begin
              if (align_bad) begin
                error_flags_next[ERR_UNALIGNED] = 1'b1;
                push_count = 2'd1;
                push0      = done_result(3'b001 << ERR_UNALIGNED);
              end else if (request_length == '0) begin
                push_count = 2'd1;
                push0      = done_result(3'b000);
              end else begin
                next_address_next = start_addr + PAGE_STEP;
                bytes_left_next   = erase_rem;
                push_count = 2'd1;
                push0      = cmd_result(KIND_ERASE, start_addr, 32'd0, 1'b1);
              end
            end else if (request_length == '0) begin
              push_count = 2'd1;
              push0      = done_result(3'b000);
            end
          end
        end
        ACT_DATA: begin
          if (mode == MODE_WRITE) begin
            bytes_left_next   = bytes_dec;
            word_buffer_next  = merged;
            lane_pointer_next = lane_inc;
            if (word_out) begin
              next_address_next = (next_address | ADDR_W'(3)) + ADDR_W'(1);
              word_buffer_next  = WORD_ONES;
              lane_pointer_next = 2'd0;
              if (bytes_dec == '0) begin
                push_count = 2'd2;
                push0      = cmd_result(KIND_PROGRAM, next_address, merged, 1'b0);
                push1      = done_result(error_flags);
              end else begin
                push_count = 2'd1;
                push0      = cmd_result(KIND_PROGRAM, next_address, merged, 1'b1);
              end
            end
          end
        end
        ACT_STEP: begin
          if (mode == MODE_ERASE) begin
            error_flags_next = step_flags;
            push_count       = 2'd1;
            if (bytes_left == '0) begin
              push0 = done_result(step_flags);
            end else begin
              next_address_next = next_address + PAGE_STEP;
              bytes_left_next   = erase_rem;
              push0 = cmd_result(KIND_ERASE, next_address, 32'd0, 1'b1);
            end
          end
        end
        default: push_count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_size  <= '0;
      mode         <= MODE_IDLE;
      next_address <= '0;
      bytes_left   <= '0;
      word_buffer  <= WORD_ONES;
      lane_pointer <= '0;
      error_flags  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_REGION_BASE: region_base <= cfg_data;
          CFG_REGION_SIZE: region_size <= cfg_data[LEN_W-1:0];
          default:         region_base <= region_base;
        endcase
      end
      mode         <= mode_next;
      next_address <= next_address_next;
      bytes_left   <= bytes_left_next;
      word_buffer  <= word_buffer_next;
      lane_pointer <= lane_pointer_next;
      error_flags  <= error_flags_next;
    end
  end

  frs_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1),
    .has_room   (q_room),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head       (head)
  );

  assign kind            = head.kind;
  assign command_address = head.command_address;
  assign program_word    = head.program_word;
  assign error_range     = head.error_range;
  assign error_unaligned = head.error_unaligned;
  assign error_fault     = head.error_fault;
  assign last            = head.last;

endmodule

>>> rtl/frs_out_queue.sv
// ----------------------------------------------------------------------------
// frs_out_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module frs_out_queue
  import frs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  push_count,
  input  result_t     push0,
  input  result_t     push1,
  output logic        has_room,
  input  logic        pop,
  output logic        head_valid,
  output result_t     head
);

  result_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;
  // room for the worst case of one item
  assign has_room   = (count <= QCNT_W'(QDEPTH - MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_count) - QCNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/frs_checker.sv
// ----------------------------------------------------------------------------
// frs_checker
// Port-level checks on the flash request sequencer's result channel.
// ----------------------------------------------------------------------------
module frs_checker
  import frs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] command_address,
  input logic [31:0] program_word,
  input logic        error_range,
  input logic        error_unaligned,
  input logic        error_fault,
  input logic        last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(command_address) && $stable(program_word)
                                && $stable(kind))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> last && command_address == 32'd0 &&
                                       program_word == 32'd0)
    else $error("done item malformed");

  a_cmd_noflags: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DONE |-> !error_range && !error_unaligned && !error_fault)
    else $error("error flag on a command item");

  a_erase_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERASE |-> last && program_word == 32'd0)
    else $error("erase item malformed");

endmodule

bind flash_request_sequencer frs_checker u_frs_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .kind            (kind),
  .command_address (command_address),
  .program_word    (program_word),
  .error_range     (error_range),
  .error_unaligned (error_unaligned),
  .error_fault     (error_fault),
  .last            (last)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for flash_request_sequencer. An item-level predictor
// tracks the request state and the region registers and queues the expected
// commands for every accepted item. A checker pops and compares each result.
// Both channels idle at random. The run covers directed cases first, then
// random erase, write, overrun and stray items under several region settings.
// ----------------------------------------------------------------------------
module tb_top;
  import frs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [23:0] request_offset = '0;
  logic [24:0] request_length = '0;
  logic        op_kind = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        erase_fault = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] command_address;
  logic [31:0] program_word;
  logic        error_range;
  logic        error_unaligned;
  logic        error_fault;
  logic        last;

  flash_request_sequencer u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [31:0] reg_base = '0;
  logic [24:0] reg_size = '0;
  mode_t       cur_mode = MODE_IDLE;
  logic [31:0] cur_addr = '0;
  logic [24:0] bytes_remaining = '0;
  logic [31:0] word_acc = WORD_ONES;
  logic [1:0]  lane_idx = '0;
  logic [2:0]  sticky_err = '0;

  result_t expected_cmds[$];
  int      err_count = 0;
  int      items_used = 0;
  int      gap_max = 17;
  int      stall_max = 17;

  function automatic void report_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void queue_cmd(kind_t k, logic [31:0] addr, logic [31:0] word,
                                    logic [2:0] flags, logic lst);
    result_t r;
    r.kind            = k;
    r.command_address = addr;
    r.program_word    = word;
    r.error_range     = flags[ERR_RANGE];
    r.error_unaligned = flags[ERR_UNALIGNED];
    r.error_fault     = flags[ERR_FAULT];
    r.last            = lst;
    expected_cmds.push_back(r);
  endfunction

  function automatic void close_request();
    queue_cmd(KIND_DONE, '0, '0, sticky_err, 1'b1);
    cur_mode = MODE_IDLE;
  endfunction

  function automatic void erase_page();
    if (bytes_remaining == 0) begin
      close_request();
    end else begin
      queue_cmd(KIND_ERASE, cur_addr, '0, '0, 1'b1);
      cur_addr = cur_addr + PAGE_STEP;
      bytes_remaining = (bytes_remaining < PAGE_LEN) ? '0 : bytes_remaining - PAGE_LEN;
    end
  endfunction

  // Returns 1 when the item is taken, 0 when the block ignores it.
  function automatic bit predict_commands(action_t act, logic [23:0] ofs, logic [24:0] len,
                                          logic op, logic [7:0] db, logic flt);
    logic [31:0] addr;
    logic [31:0] word;
    logic [25:0] span;
    case (act)
      ACT_START: begin
        if (cur_mode != MODE_IDLE) return 1'b0;
        addr = reg_base + 32'(ofs);
        sticky_err = '0;
        cur_addr = addr;
        bytes_remaining = len;
        word_acc = WORD_ONES;
        lane_idx = addr[1:0];
        span = 26'(ofs) + 26'(len);
        if (span > 26'(reg_size)) begin
          sticky_err[ERR_RANGE] = 1'b1;
          close_request();
        end else if (op == OP_ERASE) begin
          if ((addr % PAGE_BYTES) != 0 || (len % PAGE_BYTES) != 0) begin
            sticky_err[ERR_UNALIGNED] = 1'b1;
            close_request();
          end else begin
            cur_mode = MODE_ERASE;
            erase_page();
          end
        end else if (len == 0) begin
          close_request();
        end else begin
          cur_mode = MODE_WRITE;
        end
        return 1'b1;
      end
      ACT_DATA: begin
        if (cur_mode != MODE_WRITE) return 1'b0;
        word_acc[lane_idx*8 +: 8] = db;
        lane_idx = lane_idx + 2'd1;
        if (bytes_remaining != 0) bytes_remaining = bytes_remaining - 25'd1;
        if (lane_idx == 0 || bytes_remaining == 0) begin
          addr = cur_addr;
          word = word_acc;
          cur_addr = (cur_addr | 32'h3) + 32'd1;
          word_acc = WORD_ONES;
          lane_idx = '0;
          if (bytes_remaining == 0) begin
            queue_cmd(KIND_PROGRAM, addr, word, '0, 1'b0);
            close_request();
          end else begin
            queue_cmd(KIND_PROGRAM, addr, word, '0, 1'b1);
          end
        end
        return 1'b1;
      end
      ACT_STEP: begin
        if (cur_mode != MODE_ERASE) return 1'b0;
        if (flt) sticky_err[ERR_FAULT] = 1'b1;
        erase_page();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(action_t act, logic [23:0] ofs, logic [24:0] len, logic op,
                           logic [7:0] db, logic flt);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    request_offset <= ofs;
    request_length <= len;
    op_kind        <= op;
    data_byte      <= db;
    erase_fault    <= flt;
    do @(posedge clk); while (!in_ready);
    if (predict_commands(act, ofs, len, op, db, flt)) items_used++;
  endtask

  // an item the block must ignore in its present mode
  task automatic send_stray();
    action_t a;
    do a = action_t'($urandom_range(0, 3));
    while ((a == ACT_START && cur_mode == MODE_IDLE) ||
           (a == ACT_DATA && cur_mode == MODE_WRITE) ||
           (a == ACT_STEP && cur_mode == MODE_ERASE));
    send_item(a, 24'($urandom), 25'($urandom_range(0, 16777216)), 1'($urandom),
              8'($urandom), 1'($urandom));
  endtask

  task automatic complete_request();
    while (cur_mode != MODE_IDLE) begin
      if ($urandom_range(0, 9) == 0)
        send_stray();
      else if (cur_mode == MODE_WRITE)
        send_item(ACT_DATA, 24'($urandom), 25'($urandom_range(0, 16777216)), 1'($urandom),
                  8'($urandom), 1'($urandom));
      else
        send_item(ACT_STEP, 24'($urandom), 25'($urandom_range(0, 16777216)), 1'($urandom),
                  8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic write_request();
    int len;
    int room;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) len = 0;
    else if (pick < 80) len = $urandom_range(1, 12);
    else len = $urandom_range(13, 64);
    if (len > int'(reg_size)) len = int'(reg_size);
    room = int'(reg_size) - len;
    if (room > 24'hFF_FFFF) room = 24'hFF_FFFF;
    send_item(ACT_START, 24'($urandom_range(0, room)), 25'(len), OP_WRITE,
              8'($urandom), 1'($urandom));
    complete_request();
  endtask

  task automatic erase_request();
    int lead;
    int len;
    int room;
    int ofs;
    lead = (PAGE_BYTES - reg_base % PAGE_BYTES) % PAGE_BYTES;
    len = $urandom_range(0, 3) * PAGE_BYTES;
    room = int'(reg_size) - lead - len;
    if (room < 0) room = 0;
    room = room / PAGE_BYTES;
    if (room > (24'hFF_FFFF - lead) / PAGE_BYTES) room = (24'hFF_FFFF - lead) / PAGE_BYTES;
    ofs = lead + $urandom_range(0, room) * PAGE_BYTES;
    case ($urandom_range(0, 19))
      0: ofs = ofs + $urandom_range(1, PAGE_BYTES - 1);
      1: len = len + $urandom_range(1, PAGE_BYTES - 1);
      default: ;
    endcase
    send_item(ACT_START, 24'(ofs), 25'(len), OP_ERASE, 8'($urandom), 1'($urandom));
    complete_request();
  endtask

  // request that runs past the region end
  task automatic range_request();
    int ofs;
    int len;
    ofs = $urandom_range(1, 24'hFF_FFFF);
    if (ofs > int'(reg_size)) begin
      len = $urandom_range(0, 16777216);
    end else begin
      len = int'(reg_size) - ofs + 1 + $urandom_range(0, 4096);
      if (len > 16777216) len = 16777216;
    end
    send_item(ACT_START, 24'(ofs), 25'(len), 1'($urandom), 8'($urandom), 1'($urandom));
    complete_request();
  endtask

  task automatic run_random(int n);
    int target;
    int pick;
    target = items_used + n;
    while (items_used < target) begin
      if ($urandom_range(0, 9) == 0) gap_max = (gap_max == 0) ? 17 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) write_request();
      else if (pick < 80) erase_request();
      else if (pick < 92) range_request();
      else repeat ($urandom_range(1, 3)) send_stray();
    end
  endtask

  // wait until every expected result is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_REGION_BASE) reg_base = val;
    else reg_size = val[24:0];
  endtask

  task automatic set_region(logic [31:0] base, logic [24:0] size);
    settle();
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_SIZE, 32'(size));
    cfg_write <= 1'b0;
  endtask

  task automatic test_directed();
    set_region(32'h0, 25'd16777216);
    // two-page erase, fault on the first page, seen on the closing step
    send_item(ACT_START, 24'h0, 25'd8192, OP_ERASE, 8'h00, 1'b0);
    send_item(ACT_STEP, 24'h0, 25'd0, 1'b0, 8'h00, 1'b1);
    send_item(ACT_STEP, 24'h0, 25'd0, 1'b0, 8'h00, 1'b0);
    // write from an odd address: partial first and last words
    send_item(ACT_START, 24'h1, 25'd6, OP_WRITE, 8'h00, 1'b0);
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'h00, 1'b0);
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'hFF, 1'b0);
    send_item(ACT_START, 24'hFF_FFFF, 25'd16777216, OP_ERASE, 8'h00, 1'b1); // busy
    send_item(ACT_STEP, 24'h0, 25'd0, 1'b0, 8'h00, 1'b1);                   // not erasing
    send_item(ACT_NONE, 24'h0, 25'd0, 1'b0, 8'h00, 1'b0);
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'hA5, 1'b0);
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'h5A, 1'b0);
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'h01, 1'b0);
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'h80, 1'b0);
    // stray items while idle
    send_item(ACT_DATA, 24'h0, 25'd0, 1'b1, 8'h33, 1'b0);
    send_item(ACT_STEP, 24'h0, 25'd0, 1'b0, 8'h00, 1'b1);
    // empty write, empty erase, misaligned erase address and length
    send_item(ACT_START, 24'h10, 25'd0, OP_WRITE, 8'h00, 1'b0);
    send_item(ACT_START, 24'h0, 25'd0, OP_ERASE, 8'h00, 1'b0);
    send_item(ACT_START, 24'h10, 25'd4096, OP_ERASE, 8'h00, 1'b0);
    send_item(ACT_START, 24'h0, 25'd100, OP_ERASE, 8'h00, 1'b0);
    // past the region end, then requests ending exactly at it
    send_item(ACT_START, 24'hFF_FFFF, 25'd16777216, OP_WRITE, 8'h00, 1'b0);
    send_item(ACT_START, 24'hFF_F000, 25'd4096, OP_ERASE, 8'h00, 1'b0);
    send_item(ACT_STEP, 24'h0, 25'd0, 1'b0, 8'h00, 1'b0);
    send_item(ACT_START, 24'hFF_FFFC, 25'd4, OP_WRITE, 8'h00, 1'b0);
    repeat (4) send_item(ACT_DATA, 24'h0, 25'd0, 1'b0, 8'($urandom), 1'b0);
  endtask

  task automatic test_full_region();
    set_region(32'h0, 25'd16777216);
    run_random(350);
  endtask

  task automatic test_wrapping_base();
    set_region(32'hFFFF_F000, 25'h2_0000);
    run_random(350);
  endtask

  task automatic test_unaligned_base();
    set_region(32'hFFFF_FFFF, 25'h5003);
    run_random(350);
  endtask

  task automatic test_empty_region();
    set_region($urandom, 25'd0);
    run_random(300);
  endtask

  task automatic test_random_region();
    set_region($urandom, 25'($urandom_range(0, 16777216)));
    run_random(400);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_region();
    test_wrapping_base();
    test_unaligned_base();
    test_empty_region();
    test_random_region();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_cmds.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_cmds.size()));
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result side back-pressure, with runs of no stalling
  initial begin
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) stall_max = (stall_max == 0) ? 17 : 0;
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        report_error($sformatf("unexpected result kind=%0d addr=%h word=%h",
                               kind, command_address, program_word));
      end else begin
        exp_r = expected_cmds.pop_front();
        if (exp_r.kind !== kind || exp_r.command_address !== command_address ||
            exp_r.program_word !== program_word || exp_r.error_range !== error_range ||
            exp_r.error_unaligned !== error_unaligned ||
            exp_r.error_fault !== error_fault || exp_r.last !== last)
          report_error($sformatf(
            "exp kind=%0d addr=%h word=%h rng/unal/flt=%b%b%b last=%b, got kind=%0d addr=%h word=%h rng/unal/flt=%b%b%b last=%b",
            exp_r.kind, exp_r.command_address, exp_r.program_word, exp_r.error_range,
            exp_r.error_unaligned, exp_r.error_fault, exp_r.last, kind, command_address,
            program_word, error_range, error_unaligned, error_fault, last));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
